// ----- src/csrt_pkg.sv -----
// ----------------------------------------------------------------------------
// csrt_pkg: shared types for the column style run table
// Operation codes, pass kinds, controller states and the control/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package csrt_pkg;

   typedef enum logic [2:0] {
      FN_GET         = 3'd0,
      FN_SET_POINT   = 3'd1,
      FN_SET_RANGE   = 3'd2,
      FN_UNSET_POINT = 3'd3,
      FN_UNSET_RANGE = 3'd4,
      FN_INS_COLS    = 3'd5,
      FN_DEL_COLS    = 3'd6,
      FN_CLEAR       = 3'd7
   } func_type;

   // one pass streams the source bank into the destination bank
   typedef enum logic [2:0] {
      PK_GET,
      PK_REMOVE,
      PK_MERGE,
      PK_MASK,
      PK_INS,
      PK_DEL
   } pass_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PSTART,
      ST_READ,
      ST_SLOT_A,
      ST_SLOT_B,
      ST_END_A,
      ST_END_B,
      ST_PDONE,
      ST_NEXTPT,
      ST_COMMIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic     load_op;
      logic     pass_start;
      pass_type kind;
      logic     wr_a;
      logic     wr_b;
      logic     ent_valid;
      logic     update;
      logic     accept_src;
      logic     commit;
      logic     next_point;
      logic     clear;
      logic     set_full;
      logic     rsp_load;
   } ctl_type;

   typedef struct packed {
      func_type func;
      logic     op_ok;
      logic     over;
      logic     skip;
      logic     at_end;
      logic     bg_real;
      logic     p_eq_stop;
      logic     rsp_free;
   } sts_type;

   localparam logic [15:0] BG_NONE = 16'hFFFF;

endpackage

// ----- src/csrt_ram.sv -----
// ----------------------------------------------------------------------------
// csrt_ram: generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module csrt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- src/csrt_ctrl.sv -----
// ----------------------------------------------------------------------------
// csrt_ctrl: operation sequencer
// Walks each operation through its streaming passes over the run table.
// ----------------------------------------------------------------------------
module csrt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  csrt_pkg::sts_type sts,
   output csrt_pkg::ctl_type ctl
);
   import csrt_pkg::*;

   state_type state_ff, state_in;
   pass_type  kind_ff, kind_in;
   logic      is_set;

   assign is_set = (sts.func == FN_SET_POINT) || (sts.func == FN_SET_RANGE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= PK_GET;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = ST_PSTART;
            case (sts.func)
               FN_GET:      kind_in = PK_GET;
               FN_INS_COLS: kind_in = PK_INS;
               FN_DEL_COLS: kind_in = PK_DEL;
               FN_CLEAR:    state_in = ST_RESP;
               default:     kind_in = PK_REMOVE;
            endcase
            if (!sts.op_ok) state_in = ST_RESP;
         end
         ST_PSTART: state_in = ST_READ;
         ST_READ:   state_in = sts.at_end ? ST_END_A : ST_SLOT_A;
         ST_SLOT_A: state_in = ST_SLOT_B;
         ST_SLOT_B: state_in = ST_READ;
         ST_END_A:  state_in = ST_END_B;
         ST_END_B:  state_in = ST_PDONE;
         ST_PDONE: begin
            case (kind_ff)
               PK_GET: state_in = ST_RESP;
               PK_REMOVE: begin
                  if (is_set) begin
                     if (sts.skip) begin
                        state_in = ST_NEXTPT;
                     end else if (sts.over) begin
                        state_in = ST_RESP;
                     end else begin
                        kind_in  = PK_MERGE;
                        state_in = ST_PSTART;
                     end
                  end else if (sts.over) begin
                     state_in = ST_RESP;
                  end else if (sts.func == FN_UNSET_RANGE && sts.bg_real) begin
                     kind_in  = PK_MASK;
                     state_in = ST_PSTART;
                  end else begin
                     state_in = ST_COMMIT;
                  end
               end
               PK_MERGE: state_in = sts.over ? ST_RESP : ST_NEXTPT;
               PK_MASK:  state_in = sts.over ? ST_RESP : ST_COMMIT;
               default:  state_in = ST_COMMIT;
            endcase
         end
         ST_NEXTPT: begin
            if (sts.p_eq_stop) begin
               state_in = ST_COMMIT;
            end else begin
               kind_in  = PK_REMOVE;
               state_in = ST_PSTART;
            end
         end
         ST_COMMIT: state_in = ST_RESP;
         ST_RESP: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl      = '0;
      ctl.kind = kind_ff;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE:   ctl.load_op = req_tvalid;
         ST_DECODE: ctl.clear = (sts.func == FN_CLEAR);
         ST_PSTART: ctl.pass_start = 1'b1;
         ST_SLOT_A: begin
            ctl.wr_a      = 1'b1;
            ctl.ent_valid = 1'b1;
         end
         ST_SLOT_B: begin
            ctl.wr_b      = 1'b1;
            ctl.ent_valid = 1'b1;
            ctl.update    = 1'b1;
         end
         ST_END_A:  ctl.wr_a = 1'b1;
         ST_END_B: begin
            ctl.wr_b   = 1'b1;
            ctl.update = 1'b1;
         end
         ST_PDONE: begin
            case (kind_ff)
               PK_GET: ;
               PK_REMOVE: begin
                  if (!(is_set && sts.skip)) begin
                     ctl.set_full   = sts.over;
                     ctl.accept_src = !sts.over;
                  end
               end
               PK_MERGE, PK_MASK: begin
                  ctl.set_full   = sts.over;
                  ctl.accept_src = !sts.over;
               end
               default: ctl.accept_src = 1'b1;
            endcase
         end
         ST_NEXTPT: ctl.next_point = !sts.p_eq_stop;
         ST_COMMIT: ctl.commit = 1'b1;
         ST_RESP:   ctl.rsp_load = sts.rsp_free;
         default: ;
      endcase
   end

endmodule

// ----- src/csrt_dp.sv -----
// ----------------------------------------------------------------------------
// csrt_dp: run table datapath
// Three table banks; each pass reads one bank and writes a transformed copy
// into another. Holds operands, pass state, background and result register.
// ----------------------------------------------------------------------------
module csrt_dp #(
   parameter int MAX_RUNS    = 64,
   parameter int LAST_COLUMN = 255,
   parameter int STYLE_BITS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  csrt_pkg::ctl_type ctl,
   output csrt_pkg::sts_type sts,
   input  logic [2:0]        req_func,
   input  logic [7:0]        req_first_column,
   input  logic [8:0]        req_second_value,
   input  logic [15:0]       req_style_in,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [15:0]       rsp_style_out,
   output logic              rsp_found,
   output logic              rsp_table_full
);
   import csrt_pkg::*;

   localparam int CW = $clog2(LAST_COLUMN + 1);
   localparam int SB = STYLE_BITS;
   localparam int EW = 2 * CW + SB;
   localparam int IW = $clog2(MAX_RUNS);
   localparam int NW = $clog2(MAX_RUNS + 3);
   localparam int XW = ((CW > 9) ? CW : 9) + 2;
   localparam logic [XW-1:0] LAST_X = XW'(LAST_COLUMN);
   localparam logic [NW-1:0] MAX_N  = NW'(MAX_RUNS);
   localparam logic [SB-1:0] STYLE_ALL = {SB{1'b1}};

   function automatic logic [EW-1:0] pack_run(input logic [XW-1:0] l,
                                              input logic [XW-1:0] r,
                                              input logic [SB-1:0] s);
      return {s, CW'(r), CW'(l)};
   endfunction

   // operands
   func_type        func_ff;
   logic [7:0]      a_ff;
   logic [8:0]      cnt_ff;
   logic [SB-1:0]   style_ff;
   logic [XW-1:0]   stop_ff, p_ff;
   // bank bookkeeping
   logic [1:0]      cur_ff, src_ff, dst_ff;
   logic [NW-1:0]   cur_cnt_ff, src_cnt_ff, idx_ff, ocnt_ff;
   // pass state
   logic [EW-1:0]   h_ff, h_in;
   logic            hv_ff, hv_in, placed_ff, placed_in, skip_ff, got_ff, full_ff;
   logic [SB-1:0]   gsty_ff;
   logic [15:0]     bg_ff;
   logic            rsp_valid_ff;
   logic [15:0]     rsp_style_ff;
   logic            rsp_found_ff, rsp_full_ff;

   // bank access
   logic [EW-1:0]   q, q_bank [3];
   logic [EW-1:0]   wa_data, wb_data, wr_data;
   logic            wa_v, wb_v, wr_any, wr_mem;

   // entry and operand views
   logic [XW-1:0]   e_l, e_r, a_x, cnt_x, lo_x, hi_x, h_l, h_r;
   logic [XW-1:0]   nl, nr, end_x, b_x, clip_x;
   logic [SB-1:0]   e_s, h_s;
   logic            ev, is_set, outside, at, mp, mn, grow, keep;
   logic            skip_hit, get_hit, op_ok;

   assign ev     = ctl.ent_valid;
   assign e_l    = XW'(q[CW-1:0]);
   assign e_r    = XW'(q[2*CW-1:CW]);
   assign e_s    = q[EW-1:2*CW];
   assign h_l    = XW'(h_ff[CW-1:0]);
   assign h_r    = XW'(h_ff[2*CW-1:CW]);
   assign h_s    = h_ff[EW-1:2*CW];
   assign a_x    = XW'(a_ff);
   assign cnt_x  = XW'(cnt_ff);
   assign is_set = (func_ff == FN_SET_POINT) || (func_ff == FN_SET_RANGE);
   assign lo_x   = is_set ? p_ff : a_x;
   assign hi_x   = is_set ? p_ff : stop_ff;
   assign end_x  = a_x + cnt_x - XW'(1);
   assign b_x    = XW'(req_second_value);
   assign clip_x = (b_x > LAST_X) ? LAST_X : b_x;

   // per-entry transform
   always_comb begin
      wa_v      = 1'b0;
      wb_v      = 1'b0;
      wa_data   = q;
      wb_data   = q;
      h_in      = h_ff;
      hv_in     = hv_ff;
      placed_in = placed_ff;
      skip_hit  = 1'b0;
      get_hit   = 1'b0;
      outside   = 1'b0;
      at        = 1'b0;
      mp        = 1'b0;
      mn        = 1'b0;
      grow      = 1'b0;
      keep      = 1'b1;
      nl        = e_l;
      nr        = e_r;
      case (ctl.kind)
         PK_GET: begin
            get_hit = ev && (e_l <= a_x) && (a_x <= e_r);
         end
         PK_REMOVE: begin
            outside  = (e_r < lo_x) || (e_l > hi_x);
            wa_v     = ev && (outside || (e_l < lo_x));
            wa_data  = outside ? q : pack_run(e_l, lo_x - XW'(1), e_s);
            wb_v     = ev && !outside && (e_r > hi_x);
            wb_data  = pack_run(hi_x + XW'(1), e_r, e_s);
            skip_hit = ev && (e_l <= lo_x) && (lo_x <= e_r) && (e_s == style_ff);
         end
         PK_MASK: begin
            at        = !placed_ff && (!ev || (e_l > stop_ff));
            wa_v      = at;
            wa_data   = pack_run(a_x, stop_ff, STYLE_ALL);
            wb_v      = ev;
            placed_in = placed_ff | at;
         end
         PK_MERGE: begin
            at = !placed_ff && (!ev || (e_l > p_ff));
            mp = hv_ff && (h_r + XW'(1) == p_ff) && (h_s == style_ff);
            mn = ev && (e_l == p_ff + XW'(1)) && (e_s == style_ff);
            if (!at) begin
               wa_v    = hv_ff;
               wa_data = h_ff;
               h_in    = q;
               hv_in   = ev;
            end else begin
               placed_in = 1'b1;
               if (mp && mn) begin
                  h_in  = pack_run(h_l, e_r, h_s);
                  hv_in = 1'b1;
               end else if (mp) begin
                  wa_v    = 1'b1;
                  wa_data = pack_run(h_l, p_ff, h_s);
                  h_in    = q;
                  hv_in   = ev;
               end else if (mn) begin
                  wa_v    = hv_ff;
                  wa_data = h_ff;
                  h_in    = pack_run(p_ff, e_r, e_s);
                  hv_in   = 1'b1;
               end else begin
                  wa_v    = hv_ff;
                  wa_data = h_ff;
                  wb_v    = 1'b1;
                  wb_data = pack_run(p_ff, p_ff, style_ff);
                  h_in    = q;
                  hv_in   = ev;
               end
            end
         end
         PK_INS: begin
            grow    = (e_r + XW'(1)) >= a_x;
            nr      = grow ? e_r + cnt_x : e_r;
            nl      = (e_l >= a_x) ? e_l + cnt_x : e_l;
            wa_v    = ev && (nl <= LAST_X);
            wa_data = pack_run(nl, (nr > LAST_X) ? LAST_X : nr, e_s);
         end
         PK_DEL: begin
            if (e_l > end_x) begin
               nl = e_l - cnt_x;
               nr = e_r - cnt_x;
            end else if (e_l >= a_x) begin
               keep = (e_r > end_x);
               nl   = a_x;
               nr   = e_r - cnt_x;
            end else if (e_r >= end_x) begin
               nr = e_r - cnt_x;
            end else if (e_r >= a_x) begin
               nr = a_x - XW'(1);
            end
            wa_v    = ev && keep;
            wa_data = pack_run(nl, nr, e_s);
         end
         default: ;
      endcase
   end

   assign wr_any  = (ctl.wr_a && wa_v) || (ctl.wr_b && wb_v);
   assign wr_data = ctl.wr_a ? wa_data : wb_data;
   assign wr_mem  = wr_any && (ocnt_ff < MAX_N);

   for (genvar g = 0; g < 3; g++) begin : g_bank
      csrt_ram #(
         .WIDTH (EW),
         .DEPTH (MAX_RUNS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_mem && (dst_ff == 2'(g))),
         .wr_addr (ocnt_ff[IW-1:0]),
         .wr_data (wr_data),
         .rd_addr (idx_ff[IW-1:0]),
         .rd_data (q_bank[g])
      );
   end

   always_comb begin
      case (src_ff)
         2'd0:    q = q_bank[0];
         2'd1:    q = q_bank[1];
         default: q = q_bank[2];
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         cur_cnt_ff   <= '0;
         bg_ff        <= BG_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.commit) begin
            cur_ff     <= src_ff;
            cur_cnt_ff <= src_cnt_ff;
         end
         if (ctl.clear) begin
            cur_cnt_ff <= '0;
            bg_ff      <= BG_NONE;
         end else if (csr_wr_en) begin
            bg_ff <= csr_wr_data;
         end
         if (ctl.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // operands, pass state, result payload
   always_ff @(posedge clock) begin
      if (ctl.load_op) begin
         func_ff    <= func_type'(req_func);
         a_ff       <= req_first_column;
         cnt_ff     <= req_second_value;
         style_ff   <= SB'(req_style_in);
         p_ff       <= XW'(req_first_column);
         stop_ff    <= (func_type'(req_func) == FN_SET_POINT ||
                        func_type'(req_func) == FN_UNSET_POINT) ?
                       XW'(req_first_column) : clip_x;
         src_ff     <= cur_ff;
         src_cnt_ff <= cur_cnt_ff;
         got_ff     <= 1'b0;
         full_ff    <= 1'b0;
      end
      if (ctl.pass_start) begin
         idx_ff    <= '0;
         ocnt_ff   <= '0;
         hv_ff     <= 1'b0;
         placed_ff <= 1'b0;
         skip_ff   <= 1'b0;
         dst_ff    <= (src_ff == cur_ff) ? ((cur_ff == 2'd2) ? 2'd0 : cur_ff + 2'd1)
                                         : 2'd3 - src_ff - cur_ff;
      end
      if (wr_any) ocnt_ff <= ocnt_ff + NW'(1);
      if (ctl.update) begin
         h_ff      <= h_in;
         hv_ff     <= hv_in;
         placed_ff <= placed_in;
         skip_ff   <= skip_ff | skip_hit;
         if (ev) idx_ff <= idx_ff + NW'(1);
         if (get_hit && !got_ff) begin
            got_ff  <= 1'b1;
            gsty_ff <= e_s;
         end
      end
      if (ctl.accept_src) begin
         src_ff     <= dst_ff;
         src_cnt_ff <= ocnt_ff;
      end
      if (ctl.next_point) p_ff <= p_ff + XW'(1);
      if (ctl.set_full) full_ff <= 1'b1;
      if (ctl.rsp_load) begin
         rsp_full_ff <= full_ff;
         if (func_ff == FN_GET) begin
            rsp_style_ff <= got_ff ? 16'(gsty_ff) : bg_ff;
            rsp_found_ff <= got_ff || (bg_ff != BG_NONE);
         end else begin
            rsp_style_ff <= '0;
            rsp_found_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      case (func_ff)
         FN_SET_POINT:                 op_ok = a_x <= LAST_X;
         FN_SET_RANGE, FN_UNSET_RANGE: op_ok = a_x <= stop_ff;
         FN_DEL_COLS:                  op_ok = cnt_ff != '0;
         default:                      op_ok = 1'b1;
      endcase
   end

   assign sts.func      = func_ff;
   assign sts.op_ok     = op_ok;
   assign sts.over      = ocnt_ff > MAX_N;
   assign sts.skip      = skip_ff;
   assign sts.at_end    = idx_ff == src_cnt_ff;
   assign sts.bg_real   = bg_ff != BG_NONE;
   assign sts.p_eq_stop = p_ff == stop_ff;
   assign sts.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_style_out  = rsp_style_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_table_full = rsp_full_ff;

endmodule

// ----- src/column_style_run_table.sv -----
// ----------------------------------------------------------------------------
// column_style_run_table: sorted table of styled column runs
// Lookup, set/unset of points and ranges with merging, column insert and
// delete, and clear, over a table of up to MAX_RUNS runs.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  func, first_column, second_value, style_in
//  rsp      out  rsp_tvalid/rsp_tready  style_out, found, table_full
//  csr      in   csr_wr_en              background_style
//
// One item at a time. Each pass streams the run table once, reading one stored
// run after another through the single read port of the source bank. Get,
// unset, insert and delete take one pass (unset range up to two), set point up
// to two, set range up to two per column.
// Reset empties the table without a clearing pass.
// A result waiting on rsp holds only the next item's result stage, not
// its intake.
//
module column_style_run_table #(
   parameter int MAX_RUNS    = 64,
   parameter int LAST_COLUMN = 255,
   parameter int STYLE_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request beat
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] func, [10:3] first_column, [19:11] second_value,
   // [35:20] style_in, [39:36] zero
   input  logic [39:0] req_tdata,
   // response beat
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] style_out, [16] found, [17] table_full, [23:18] zero
   output logic [23:0] rsp_tdata,
   // background style register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import csrt_pkg::*;

   ctl_type     ctl;
   sts_type     sts;
   logic [15:0] style_out;
   logic        found, table_full;

   // sequencer: one state per pass phase
   csrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   // banks, pass transform, background and result register
   csrt_dp #(
      .MAX_RUNS    (MAX_RUNS),
      .LAST_COLUMN (LAST_COLUMN),
      .STYLE_BITS  (STYLE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .sts              (sts),
      .req_func         (req_tdata[2:0]),
      .req_first_column (req_tdata[10:3]),
      .req_second_value (req_tdata[19:11]),
      .req_style_in     (req_tdata[35:20]),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_style_out    (style_out),
      .rsp_found        (found),
      .rsp_table_full   (table_full)
   );

   assign rsp_tdata = {6'd0, table_full, found, style_out};

endmodule
